FILE: rtl/chu_pkg.sv
// Package with the constants and the CORDIC angle table of the compass heading unwrapper.
`default_nettype none
package chu_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int AW = 32;
    localparam logic signed [AW-1:0] DEG90_Q16 = 32'sd5898240;
    localparam logic signed [AW-1:0] PHI_TO_DEG = 32'sd30039490;
    localparam logic signed [19:0] HALF_TURN_Q8 = 20'sd46080;
    localparam logic signed [19:0] FULL_TURN_Q8 = 20'sd92160;
    localparam logic signed [19:0] JUMP_Q8 = 20'sd64000;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_HEADING_OFFSET = 3'd2,
        REG_TILT_ANGLE = 3'd3,
        REG_AXIS_RATIO = 3'd4
    } reg_index_t;

    function automatic logic signed [AW-1:0] atan_deg(input logic [3:0] i);
        logic signed [AW-1:0] r;
        begin
            case (i)
                4'd0: r = 32'sd2949120;
                4'd1: r = 32'sd1740967;
                4'd2: r = 32'sd919879;
                4'd3: r = 32'sd466945;
                4'd4: r = 32'sd234379;
                4'd5: r = 32'sd117304;
                4'd6: r = 32'sd58666;
                4'd7: r = 32'sd29335;
                4'd8: r = 32'sd14668;
                4'd9: r = 32'sd7334;
                4'd10: r = 32'sd3667;
                4'd11: r = 32'sd1833;
                4'd12: r = 32'sd917;
                4'd13: r = 32'sd458;
                4'd14: r = 32'sd229;
                default: r = 32'sd115;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

FILE: rtl/compass_heading_unwrapper.sv
// Top level of the compass heading unwrapper: calibration, CORDIC, division and turn tracking.
`default_nettype none
// The tilt takes up to two quarter-turn folds, the shared CORDIC registers run 16 rotation
// steps, a restoring divider takes 40 steps to scale x by the axis ratio, and vectoring takes
// an optional quarter turn and 16 steps, or none for a zero vector. Further states cover
// rounding, wrapping, turn tracking and output. in_stall is high while a sample is in work
// and while its result waits, so the next sample is accepted in the cycle after the result
// beat leaves. MAX_TURNS bounds the saturating turn counter.
module compass_heading_unwrapper #(
    parameter int MAX_TURNS = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire [2:0]          cfg_index,
    input  wire [16:0]         cfg_data,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire signed [15:0]  mag_x,
    input  wire signed [15:0]  mag_y,
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [23:0] heading,
    output logic signed [7:0]  turns
);
    typedef enum logic [3:0] {
        S_IDLE, S_PHI, S_FOLD, S_ROT, S_DIVSET, S_DIV, S_DIVFIN, S_VEC, S_FIN1, S_FIN2,
        S_FIN3, S_OUT
    } state_t;

    localparam int W = 40;
    localparam logic signed [7:0] MAXT = 8'(MAX_TURNS);

    logic signed [15:0] cx_reg, cy_reg, phi_reg;
    logic signed [16:0] off_reg;
    logic [15:0] ratio_reg;

    state_t state_reg;
    logic signed [W-1:0] x_reg, y_reg;
    logic signed [31:0] z_reg, phi16_reg;
    logic signed [47:0] prod_reg;
    logic [5:0] step_reg;
    logic [W-1:0] quo_reg, rem_reg;
    logic xneg_reg;
    logic signed [19:0] ang_reg;
    logic signed [16:0] last_reg;
    logic signed [7:0] tc_reg;
    logic signed [23:0] heading_reg;

    logic signed [W-1:0] xs, ys;
    logic [W:0] trial;
    logic signed [31:0] tab;
    logic signed [19:0] m, wr;
    logic signed [19:0] diff;
    logic signed [31:0] hd;
    logic [15:0] ratio_eff;
    logic signed [32:0] rnd;

    assign xs = x_reg >>> step_reg[3:0];
    assign ys = y_reg >>> step_reg[3:0];
    assign tab = chu_pkg::atan_deg(step_reg[3:0]);
    assign ratio_eff = (ratio_reg == 16'd0) ? 16'd1 : ratio_reg;
    assign trial = {rem_reg, quo_reg[W-1]} - {25'd0, ratio_eff};
    assign rnd = 33'(prod_reg[47:16]);

    always_comb
    begin
        m = ang_reg + chu_pkg::HALF_TURN_Q8;
        if (m < 0) m = m + chu_pkg::FULL_TURN_Q8;
        if (m < 0) m = m + chu_pkg::FULL_TURN_Q8;
        if (m >= chu_pkg::FULL_TURN_Q8) m = m - chu_pkg::FULL_TURN_Q8;
        if (m >= chu_pkg::FULL_TURN_Q8) m = m - chu_pkg::FULL_TURN_Q8;
        wr = m - chu_pkg::HALF_TURN_Q8;
        diff = wr - 20'(last_reg);
    end

    assign hd = 32'(ang_reg) + 32'(tc_reg) * 32'(chu_pkg::FULL_TURN_Q8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            off_reg <= '0;
            phi_reg <= '0;
            ratio_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                chu_pkg::REG_CENTER_X: cx_reg <= cfg_data[15:0];
                chu_pkg::REG_CENTER_Y: cy_reg <= cfg_data[15:0];
                chu_pkg::REG_HEADING_OFFSET: off_reg <= cfg_data;
                chu_pkg::REG_TILT_ANGLE: phi_reg <= cfg_data[15:0];
                chu_pkg::REG_AXIS_RATIO: ratio_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg <= '0;
            tc_reg <= '0;
            out_valid <= 1'b0;
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
            phi16_reg <= '0;
            prod_reg <= '0;
            step_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
            xneg_reg <= 1'b0;
            ang_reg <= '0;
            heading_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg <= W'((32'(mag_x) - 32'(cx_reg)) * 256);
                        y_reg <= W'((32'(mag_y) - 32'(cy_reg)) * 256);
                        prod_reg <= 48'(phi_reg < 0 ? -32'(phi_reg) : 32'(phi_reg))
                                    * 48'(chu_pkg::PHI_TO_DEG);
                        state_reg <= S_PHI;
                    end
                end
                S_PHI:
                begin
                    phi16_reg <= (phi_reg < 0) ? -32'((prod_reg + 48'sd32768) >>> 16)
                                               : 32'((prod_reg + 48'sd32768) >>> 16);
                    z_reg <= (phi_reg < 0) ? 32'((prod_reg + 48'sd32768) >>> 16)
                                           : -32'((prod_reg + 48'sd32768) >>> 16);
                    step_reg <= '0;
                    state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    if (z_reg > chu_pkg::DEG90_Q16)
                    begin
                        x_reg <= -y_reg;
                        y_reg <= x_reg;
                        z_reg <= z_reg - chu_pkg::DEG90_Q16;
                    end
                    else if (z_reg < -chu_pkg::DEG90_Q16)
                    begin
                        x_reg <= y_reg;
                        y_reg <= -x_reg;
                        z_reg <= z_reg + chu_pkg::DEG90_Q16;
                    end
                    else
                        state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (z_reg >= 0)
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - tab;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + tab;
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(chu_pkg::CORDIC_STEPS - 1))
                        state_reg <= S_DIVSET;
                end
                S_DIVSET:
                begin
                    xneg_reg <= x_reg < 0;
                    quo_reg <= (x_reg < 0) ? W'(-x_reg) << 12 : W'(x_reg) << 12;
                    rem_reg <= '0;
                    step_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!trial[W])
                        rem_reg <= trial[W-1:0];
                    else
                        rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                    quo_reg <= {quo_reg[W-2:0], ~trial[W]};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(W - 1))
                        state_reg <= S_DIVFIN;
                end
                S_DIVFIN:
                begin
                    x_reg <= xneg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                    step_reg <= '0;
                    z_reg <= '0;
                    state_reg <= S_VEC;
                end
                S_VEC:
                begin
                    if (step_reg == 6'd0 && x_reg == 0 && y_reg == 0)
                    begin
                        z_reg <= '0;
                        state_reg <= S_FIN1;
                    end
                    else if (step_reg == 6'd0 && x_reg < 0)
                    begin
                        if (y_reg >= 0)
                        begin
                            x_reg <= y_reg;
                            y_reg <= -x_reg;
                            z_reg <= chu_pkg::DEG90_Q16;
                        end
                        else
                        begin
                            x_reg <= -y_reg;
                            y_reg <= x_reg;
                            z_reg <= -chu_pkg::DEG90_Q16;
                        end
                    end
                    else
                    begin
                        if (y_reg >= 0)
                        begin
                            x_reg <= x_reg + ys;
                            y_reg <= y_reg - xs;
                            z_reg <= z_reg + tab;
                        end
                        else
                        begin
                            x_reg <= x_reg - ys;
                            y_reg <= y_reg + xs;
                            z_reg <= z_reg - tab;
                        end
                        step_reg <= step_reg + 6'd1;
                        if (step_reg == 6'(chu_pkg::CORDIC_STEPS - 1))
                            state_reg <= S_FIN1;
                    end
                end
                S_FIN1:
                begin
                    prod_reg <= 48'(z_reg + phi16_reg + 32'sd128) <<< 8;
                    state_reg <= S_FIN2;
                end
                S_FIN2:
                begin
                    ang_reg <= 20'(rnd) - 20'(off_reg);
                    state_reg <= S_FIN3;
                end
                S_FIN3:
                begin
                    ang_reg <= wr;
                    last_reg <= 17'(wr);
                    if (diff < -chu_pkg::JUMP_Q8)
                    begin
                        if (tc_reg < MAXT)
                            tc_reg <= tc_reg + 8'sd1;
                    end
                    else if (diff > chu_pkg::JUMP_Q8)
                    begin
                        if (tc_reg > -MAXT)
                            tc_reg <= tc_reg - 8'sd1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid)
                    begin
                        if (hd > 32'sd8388607)
                            heading_reg <= 24'sd8388607;
                        else if (hd < -32'sd8388608)
                            heading_reg <= -24'sd8388608;
                        else
                            heading_reg <= 24'(hd);
                        out_valid <= 1'b1;
                    end
                    else if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign heading = heading_reg;
    assign turns = tc_reg;
endmodule
`default_nettype wire

FILE: bench/compass_heading_unwrapper_tb.sv
// Testbench for the compass heading unwrapper: directed table, random samples and turn tracking.
`timescale 1ns / 100ps
module compass_heading_unwrapper_tb;
    localparam int MAX_TURN_COUNT = 64;
    localparam int SETTLE_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [16:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic out_valid;
    logic out_stall;
    logic signed [23:0] heading;
    logic signed [7:0] turns;

    compass_heading_unwrapper #(.MAX_TURNS(MAX_TURN_COUNT)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .mag_x(mag_x), .mag_y(mag_y), .out_valid(out_valid), .out_stall(out_stall),
        .heading(heading), .turns(turns)
    );

    typedef struct packed {
        logic signed [23:0] heading;
        logic signed [7:0] turns;
    } heading_beat_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit known;
        logic signed [23:0] heading;
        logic signed [7:0] turns;
    } sample_row_t;

    longint cal_cx, cal_cy, cal_off, cal_phi, cal_ratio;
    longint prev_wrapped, turn_total;
    heading_beat_t expected_headings[$];
    int errors;
    int samples_sent;
    int headings_seen;
    bit idle_enable;
    bit hold_output;

    localparam longint atan_table[16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic void cal_reset();
        cal_cx = 0;
        cal_cy = 0;
        cal_off = 0;
        cal_phi = 0;
        cal_ratio = 4096;
        prev_wrapped = 0;
        turn_total = 0;
    endfunction

    function automatic void cal_write(chu_pkg::reg_index_t idx, logic [16:0] value);
        case (idx)
            chu_pkg::REG_CENTER_X: cal_cx = longint'($signed(value[15:0]));
            chu_pkg::REG_CENTER_Y: cal_cy = longint'($signed(value[15:0]));
            chu_pkg::REG_HEADING_OFFSET: cal_off = longint'($signed(value));
            chu_pkg::REG_TILT_ANGLE: cal_phi = longint'($signed(value[15:0]));
            chu_pkg::REG_AXIS_RATIO: cal_ratio = longint'(value[15:0]);
            default: ;
        endcase
    endfunction

    function automatic heading_beat_t predict_heading(logic signed [15:0] mx,
                                                     logic signed [15:0] my);
        longint x, y, z, t, xs, ys, ratio, mag, phi16, acc, ang, wrapped, diff, head;
        heading_beat_t r;
        x = (longint'(mx) - cal_cx) * 256;
        y = (longint'(my) - cal_cy) * 256;
        ratio = (cal_ratio == 0) ? 1 : cal_ratio;
        mag = (cal_phi < 0) ? -cal_phi : cal_phi;
        phi16 = (mag * 30039490 + 32768) / 65536;
        if (cal_phi < 0)
            phi16 = -phi16;
        z = -phi16;
        while (z > 5898240)
        begin
            t = x; x = -y; y = t; z -= 5898240;
        end
        while (z < -5898240)
        begin
            t = x; x = y; y = -t; z += 5898240;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_table[i];
            end
            else
            begin
                x += ys; y -= xs; z += atan_table[i];
            end
        end
        x = (x * 4096) / ratio;
        acc = 0;
        if (!(x == 0 && y == 0))
        begin
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x; x = y; y = -t; acc = 5898240;
                end
                else
                begin
                    t = x; x = -y; y = t; acc = -5898240;
                end
            end
            for (int i = 0; i < 16; i++)
            begin
                xs = floor_shift(x, i);
                ys = floor_shift(y, i);
                if (y >= 0)
                begin
                    x += ys; y -= xs; acc += atan_table[i];
                end
                else
                begin
                    x -= ys; y += xs; acc -= atan_table[i];
                end
            end
        end
        ang = floor_div(acc + phi16 + 128, 256) - cal_off;
        wrapped = ang + 46080 - floor_div(ang + 46080, 92160) * 92160 - 46080;
        diff = wrapped - prev_wrapped;
        if (diff < -64000)
        begin
            if (turn_total < MAX_TURN_COUNT)
                turn_total++;
        end
        else if (diff > 64000)
        begin
            if (turn_total > -MAX_TURN_COUNT)
                turn_total--;
        end
        prev_wrapped = wrapped;
        head = wrapped + turn_total * 92160;
        if (head > 8388607)
            head = 8388607;
        if (head < -8388608)
            head = -8388608;
        r.heading = head[23:0];
        r.turns = turn_total[7:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("compass_heading_unwrapper: mismatch");
        $finish;
    end

    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y);
        heading_beat_t e;
        while (idle_enable && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mag_x <= x;
        mag_y <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        e = predict_heading(x, y);
        expected_headings.push_back(e);
        samples_sent++;
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (expected_headings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(chu_pkg::reg_index_t idx, logic [16:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cal_write(idx, value);
        @(posedge clk);
    endtask

    task automatic directed_table();
        sample_row_t rows[$];
        heading_beat_t e;
        // A zero vector sent after a first sample along +x reads zero degrees with no turns.
        rows.push_back('{16'sd1000, 16'sd0, 1'b0, 0, 0});
        rows.push_back('{16'sd0, 16'sd0, 1'b1, 24'sd0, 8'sd0});
        rows.push_back('{16'sd0, 16'sd1000, 1'b0, 0, 0});
        rows.push_back('{-16'sd1000, 16'sd0, 1'b0, 0, 0});
        rows.push_back('{-16'sd1000, -16'sd5, 1'b0, 0, 0});
        rows.push_back('{16'sh7fff, 16'sh7fff, 1'b0, 0, 0});
        rows.push_back('{-16'sh8000, -16'sh8000, 1'b0, 0, 0});
        rows.push_back('{16'sh7fff, -16'sh8000, 1'b0, 0, 0});
        rows.push_back('{-16'sh8000, 16'sh7fff, 1'b0, 0, 0});
        rows.push_back('{-16'sd1000, 16'sd5, 1'b0, 0, 0});
        rows.push_back('{16'sd0, -16'sd1000, 1'b0, 0, 0});
        rows.push_back('{16'sd1, 16'sd0, 1'b0, 0, 0});
        foreach (rows[i])
        begin
            send_sample(rows[i].x, rows[i].y);
            if (rows[i].known)
            begin
                e = expected_headings[$];
                if (e.heading !== rows[i].heading || e.turns !== rows[i].turns)
                begin
                    $display("%0t row %0d: table %0d/%0d, model %0d/%0d", $time, i,
                             rows[i].heading, rows[i].turns, e.heading, e.turns);
                    errors++;
                end
            end
        end
    endtask

    // Spinning sequences rotate steadily so the turn counter walks far in one direction.
    task automatic spin_run(int count, bit ccw);
        int a;
        real r;
        a = $urandom_range(359);
        for (int i = 0; i < count; i++)
        begin
            a = ccw ? a + $urandom_range(40, 90) : a - $urandom_range(40, 90);
            r = 8000.0 + $urandom_range(8000);
            send_sample(16'(int'(r * $cos(a * 3.14159265 / 180.0))),
                        16'(int'(r * $sin(a * 3.14159265 / 180.0))));
        end
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0: send_sample(16'($urandom), 16'($urandom));
                1: send_sample(16'($signed($urandom_range(400)) - 200),
                               16'($signed($urandom_range(400)) - 200));
                default:
                begin
                    spin_run(20, $urandom_range(1));
                    i += 19;
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mag_x = '0;
        mag_y = '0;
        errors = 0;
        samples_sent = 0;
        idle_enable = 1'b0;
        cal_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_table();
        drain_and_settle();

        write_register(chu_pkg::REG_CENTER_X, 17'(-16'sd300));
        write_register(chu_pkg::REG_CENTER_Y, 17'(16'sd450));
        write_register(chu_pkg::REG_HEADING_OFFSET, 17'(17'sd12000));
        write_register(chu_pkg::REG_TILT_ANGLE, 17'(16'sd3000));
        write_register(chu_pkg::REG_AXIS_RATIO, 17'd5000);
        random_phase(300);
        drain_and_settle();

        idle_enable = 1'b1;
        write_register(chu_pkg::REG_CENTER_X, 17'(16'sh7fff));
        write_register(chu_pkg::REG_CENTER_Y, 17'(-16'sh8000));
        write_register(chu_pkg::REG_HEADING_OFFSET, 17'(17'sd46080));
        write_register(chu_pkg::REG_TILT_ANGLE, 17'(16'sd25736));
        write_register(chu_pkg::REG_AXIS_RATIO, 17'd65535);
        random_phase(150);
        drain_and_settle();

        write_register(chu_pkg::REG_CENTER_X, 17'(-16'sh8000));
        write_register(chu_pkg::REG_CENTER_Y, 17'(16'sh7fff));
        write_register(chu_pkg::REG_HEADING_OFFSET, 17'(-17'sd46080));
        write_register(chu_pkg::REG_TILT_ANGLE, 17'(-16'sd25736));
        write_register(chu_pkg::REG_AXIS_RATIO, 17'd0);
        random_phase(150);
        drain_and_settle();

        write_register(chu_pkg::REG_AXIS_RATIO, 17'd1);
        write_register(chu_pkg::REG_TILT_ANGLE, 17'(16'sh7fff));
        random_phase(100);
        drain_and_settle();

        write_register(chu_pkg::REG_CENTER_X, 17'd0);
        write_register(chu_pkg::REG_CENTER_Y, 17'd0);
        write_register(chu_pkg::REG_TILT_ANGLE, 17'(-16'sh8000));
        write_register(chu_pkg::REG_HEADING_OFFSET, 17'($urandom));
        write_register(chu_pkg::REG_AXIS_RATIO, 17'd4096);
        // A long counterclockwise spin pushes the turn counter into saturation, then a clockwise spin walks it back.
        spin_run(400, 1'b1);
        spin_run(250, 1'b0);
        drain_and_settle();

        write_register(chu_pkg::REG_CENTER_X, 17'($urandom));
        write_register(chu_pkg::REG_CENTER_Y, 17'($urandom));
        write_register(chu_pkg::REG_HEADING_OFFSET,
                       17'($signed($urandom_range(92160)) - 46080));
        write_register(chu_pkg::REG_TILT_ANGLE, 17'($urandom));
        write_register(chu_pkg::REG_AXIS_RATIO, 17'($urandom_range(2000, 9000)));
        random_phase(100);
        drain_and_settle();

        $display("Covered %0d samples and %0d headings over six register settings,",
                 samples_sent, headings_seen);
        $display("including extreme centers, tilts, ratios and saturated turn counts.");
        if (errors == 0)
            $display("compass_heading_unwrapper: match");
        else
            $display("compass_heading_unwrapper: mismatch");
        $finish;
    end

    initial
    begin
        int hold_cycles;
        hold_output = 1'b0;
        wait (samples_sent > 330);
        hold_output = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 600)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        hold_output = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_output || (idle_enable && $urandom_range(99) < 23);
    end

    always @(posedge clk)
    begin
        heading_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            headings_seen++;
            if (expected_headings.size() == 0)
            begin
                $display("%0t unexpected beat: heading %0d turns %0d", $time, heading, turns);
                errors++;
            end
            else
            begin
                e = expected_headings.pop_front();
                if (heading !== e.heading)
                begin
                    $display("%0t heading expected %0d actual %0d", $time, e.heading, heading);
                    errors++;
                end
                if (turns !== e.turns)
                begin
                    $display("%0t turns expected %0d actual %0d", $time, e.turns, turns);
                    errors++;
                end
            end
        end
    end

    initial headings_seen = 0;
endmodule
